// File: rtl/complex_integer_alu_core_defines.svh
// ---------------------------------------------------------------------------
// Complex integer ALU assertion macros
// Clocked assertion helpers shared by the RTL; ASSERT_OFF compiles them out.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_ALU_CORE_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CIA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("complex_integer_alu_core assertion failed");
// expression must never be true outside reset
`define CIA_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("complex_integer_alu_core forbidden condition");
`else
`define CIA_ASSERT(lbl, prop)
`define CIA_NEVER(lbl, expr)
`endif

`endif

// File: rtl/cia_pkg.sv
// ---------------------------------------------------------------------------
// Complex integer ALU package
// Opcodes, sequencer states and the multiply-accumulate term program.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cia_pkg;

    localparam logic [2:0] OP_PASS = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_RED_INIT,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FINISH
    } state_t;

    // operand sources of the shared shift-add multiplier
    typedef enum logic [2:0] {
        SRC_AR,
        SRC_AI,
        SRC_BR,
        SRC_BI,
        SRC_RE,
        SRC_IM
    } src_t;

    typedef struct packed {
        src_t xs;
        src_t ys;
        logic neg;
    } term_t;

    // Terms are consumed in pairs; the accumulator is stored after each odd term.
    // Multiply: re = ar*br - ai*bi, im = ar*bi + ai*br, mag = re*re + im*im.
    // Divide:   den = br*br + bi*bi, nr = ar*br + ai*bi, ni = ai*br - ar*bi.
    function automatic term_t term_of(input logic div, input logic [2:0] p);
        term_t t;
        t = '{xs: SRC_RE, ys: SRC_RE, neg: 1'b0};
        unique case (p)
            3'd0: t = div ? term_t'{SRC_BR, SRC_BR, 1'b0} : term_t'{SRC_AR, SRC_BR, 1'b0};
            3'd1: t = div ? term_t'{SRC_BI, SRC_BI, 1'b0} : term_t'{SRC_AI, SRC_BI, 1'b1};
            3'd2: t = div ? term_t'{SRC_AR, SRC_BR, 1'b0} : term_t'{SRC_AR, SRC_BI, 1'b0};
            3'd3: t = '{SRC_AI, div ? SRC_BI : SRC_BR, 1'b0};
            3'd4: t = div ? term_t'{SRC_AI, SRC_BR, 1'b0} : term_t'{SRC_RE, SRC_RE, 1'b0};
            3'd5: t = div ? term_t'{SRC_AR, SRC_BI, 1'b1} : term_t'{SRC_IM, SRC_IM, 1'b0};
            default: t = '{SRC_RE, SRC_RE, 1'b0};
        endcase
        return t;
    endfunction

endpackage

// File: rtl/complex_integer_alu_core.sv
// ---------------------------------------------------------------------------
// Complex integer ALU core
// Pass, add, subtract, multiply with squared magnitude, and exact division of
// Gaussian integers returned as two GCD-reduced fractions.
// ---------------------------------------------------------------------------
// One item at a time. Products come from one shared 64-bit shift-add unit,
// one multiplier bit per cycle: W multiplier bits per operand product and
// 2W+2 per square of a result (W = OPERAND_WIDTH), with a load state per term.
// Pass/add/subtract run only the squared-magnitude terms, multiply all terms.
// Divide forms its products, then per fraction runs a binary GCD and two
// restoring divisions of 64 quotient bits; a zero numerator skips its
// fraction, a zero divisor ends right after the denominator.
// A finished item sits in the output register while the next one is taken.
`timescale 1ns / 1ps
`include "complex_integer_alu_core_defines.svh"

module complex_integer_alu_core
    import cia_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    localparam int IN_W = ((3 + 4 * OPERAND_WIDTH + 7) / 8) * 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // opcode, a_real, a_imag, b_real, b_imag
    input  logic [IN_W-1:0] s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // res_real, res_imag, real_den, imag_den, magnitude_sq
    output logic [199:0]    m_tdata,
    // div_zero
    output logic            m_tuser
);

    localparam int W       = OPERAND_WIDTH;
    localparam int NB_WIDE = 2 * W + 2;

    state_t state_reg, state_next;

    logic signed [W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic        div_reg;
    logic [2:0]  p_reg;
    logic [63:0] acc_reg, x_reg, y_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] re_reg, im_reg, den_reg;
    logic        frac_reg;
    logic [63:0] an_reg, u_reg, v_reg, g_reg, dq_reg, qn_reg;
    logic [64:0] rem_reg;
    logic [5:0]  k_reg;

    logic [32:0] st_real_reg, st_imag_reg;
    logic [31:0] st_rden_reg, st_iden_reg;
    logic [63:0] st_mag_reg;
    logic        st_dz_reg;

    logic [32:0] out_real_reg, out_imag_reg;
    logic [31:0] out_rden_reg, out_iden_reg;
    logic [63:0] out_mag_reg;
    logic        out_dz_reg;
    logic        out_valid_reg;

    term_t       term;
    logic [63:0] acc_new;
    logic        mac_last, wide_term, div_last;
    logic [63:0] num_sel, an_sel;
    logic [64:0] rem_sh;
    logic        q_bit;
    logic [63:0] dq_new;
    logic        load_out;
    logic        div_active, dz_payload_ok;

    function automatic logic [63:0] src_val(input src_t s, input logic signed [W-1:0] ar,
        input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
        input logic signed [W-1:0] bi, input logic [63:0] re, input logic [63:0] im);
        logic [63:0] v;
        unique case (s)
            SRC_AR:  v = 64'(ar);
            SRC_AI:  v = 64'(ai);
            SRC_BR:  v = 64'(br);
            SRC_BI:  v = 64'(bi);
            SRC_RE:  v = re;
            SRC_IM:  v = im;
            default: v = re;
        endcase
        return v;
    endfunction

    assign term      = term_of(div_reg, p_reg);
    assign wide_term = (term.ys == SRC_RE) || (term.ys == SRC_IM);
    assign mac_last  = wide_term ? (cnt_reg == 6'(NB_WIDE - 1)) : (cnt_reg == 6'(W - 1));

    // last multiplier bit carries negative weight
    always_comb
    begin
        acc_new = acc_reg;
        if (y_reg[0])
        begin
            if (term.neg ^ mac_last)
                acc_new = acc_reg - x_reg;
            else
                acc_new = acc_reg + x_reg;
        end
    end

    assign num_sel  = frac_reg ? im_reg : re_reg;
    assign an_sel   = num_sel[63] ? (64'd0 - num_sel) : num_sel;
    assign rem_sh   = {rem_reg[63:0], dq_reg[63]};
    assign q_bit    = rem_sh >= {1'b0, g_reg};
    assign dq_new   = {dq_reg[62:0], q_bit};
    assign div_last = cnt_reg == 6'd63;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_MAC;
            ST_MAC:
                if (mac_last)
                begin
                    priority if (!p_reg[0])
                        state_next = ST_LOAD;
                    else if (div_reg && p_reg == 3'd1 && acc_new == 64'd0)
                        state_next = ST_FINISH;
                    else if (p_reg == 3'd5)
                        state_next = div_reg ? ST_RED_INIT : ST_FINISH;
                    else
                        state_next = ST_LOAD;
                end
            ST_RED_INIT:
                if (an_sel != 64'd0)
                    state_next = ST_GCD;
                else if (frac_reg)
                    state_next = ST_FINISH;
            ST_GCD:
                if (u_reg == 64'd0)
                    state_next = ST_DIVN;
            ST_DIVN:
                if (div_last)
                    state_next = ST_DIVD;
            ST_DIVD:
                if (div_last)
                    state_next = frac_reg ? ST_FINISH : ST_RED_INIT;
            ST_FINISH:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = state_reg == ST_IDLE;
        m_tvalid = out_valid_reg;
        m_tuser  = out_dz_reg;
        m_tdata  = {6'd0, out_mag_reg, out_iden_reg, out_rden_reg, out_imag_reg, out_real_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    ar_reg      <= s_tdata[3 +: W];
                    ai_reg      <= s_tdata[3 + W +: W];
                    br_reg      <= s_tdata[3 + 2 * W +: W];
                    bi_reg      <= s_tdata[3 + 3 * W +: W];
                    div_reg     <= s_tdata[2:0] == OP_DIV;
                    p_reg       <= (s_tdata[2:0] == OP_DIV || s_tdata[2:0] == OP_MUL)
                                   ? 3'd0 : 3'd4;
                    acc_reg     <= 64'd0;
                    frac_reg    <= 1'b0;
                    st_rden_reg <= 32'd1;
                    st_iden_reg <= 32'd1;
                    st_dz_reg   <= 1'b0;
                    priority if (s_tdata[2:0] == OP_ADD)
                    begin
                        re_reg <= 64'(signed'(s_tdata[3 +: W]))
                                + 64'(signed'(s_tdata[3 + 2 * W +: W]));
                        im_reg <= 64'(signed'(s_tdata[3 + W +: W]))
                                + 64'(signed'(s_tdata[3 + 3 * W +: W]));
                    end
                    else if (s_tdata[2:0] == OP_SUB)
                    begin
                        re_reg <= 64'(signed'(s_tdata[3 +: W]))
                                - 64'(signed'(s_tdata[3 + 2 * W +: W]));
                        im_reg <= 64'(signed'(s_tdata[3 + W +: W]))
                                - 64'(signed'(s_tdata[3 + 3 * W +: W]));
                    end
                    else
                    begin
                        re_reg <= 64'(signed'(s_tdata[3 +: W]));
                        im_reg <= 64'(signed'(s_tdata[3 + W +: W]));
                    end
                end
            ST_LOAD:
            begin
                x_reg   <= src_val(term.xs, ar_reg, ai_reg, br_reg, bi_reg, re_reg, im_reg);
                y_reg   <= src_val(term.ys, ar_reg, ai_reg, br_reg, bi_reg, re_reg, im_reg);
                cnt_reg <= 6'd0;
            end
            ST_MAC:
            begin
                acc_reg <= acc_new;
                x_reg   <= {x_reg[62:0], 1'b0};
                y_reg   <= {1'b0, y_reg[63:1]};
                cnt_reg <= cnt_reg + 6'd1;
                if (mac_last)
                begin
                    p_reg <= p_reg + 3'd1;
                    if (p_reg[0])
                    begin
                        acc_reg <= 64'd0;
                        unique case (p_reg)
                            3'd1:
                                if (div_reg)
                                begin
                                    den_reg <= acc_new;
                                    if (acc_new == 64'd0)
                                    begin
                                        st_dz_reg   <= 1'b1;
                                        st_real_reg <= 33'd0;
                                        st_imag_reg <= 33'd0;
                                        st_mag_reg  <= 64'd0;
                                    end
                                end
                                else
                                    re_reg <= acc_new;
                            3'd3:
                                if (div_reg)
                                    re_reg <= acc_new;
                                else
                                    im_reg <= acc_new;
                            default:
                                if (div_reg)
                                begin
                                    im_reg     <= acc_new;
                                    st_mag_reg <= 64'd0;
                                end
                                else
                                begin
                                    st_mag_reg  <= acc_new;
                                    st_real_reg <= re_reg[32:0];
                                    st_imag_reg <= im_reg[32:0];
                                end
                        endcase
                    end
                end
            end
            ST_RED_INIT:
                if (an_sel == 64'd0)
                begin
                    // zero numerator reduces to 0/1
                    if (frac_reg)
                    begin
                        st_imag_reg <= 33'd0;
                        st_iden_reg <= 32'd1;
                    end
                    else
                    begin
                        st_real_reg <= 33'd0;
                        st_rden_reg <= 32'd1;
                    end
                    frac_reg <= 1'b1;
                end
                else
                begin
                    an_reg <= an_sel;
                    u_reg  <= an_sel;
                    v_reg  <= den_reg;
                    k_reg  <= 6'd0;
                end
            ST_GCD:
            begin
                // binary GCD, one step per cycle
                priority if (u_reg == 64'd0)
                begin
                    g_reg   <= v_reg << k_reg;
                    dq_reg  <= an_reg;
                    rem_reg <= 65'd0;
                    cnt_reg <= 6'd0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_reg <= (u_reg - v_reg) >> 1;
                else
                    v_reg <= (v_reg - u_reg) >> 1;
            end
            ST_DIVN:
            begin
                rem_reg <= q_bit ? (rem_sh - {1'b0, g_reg}) : rem_sh;
                dq_reg  <= dq_new;
                cnt_reg <= cnt_reg + 6'd1;
                if (div_last)
                begin
                    qn_reg  <= dq_new;
                    dq_reg  <= den_reg;
                    rem_reg <= 65'd0;
                end
            end
            ST_DIVD:
            begin
                rem_reg <= q_bit ? (rem_sh - {1'b0, g_reg}) : rem_sh;
                dq_reg  <= dq_new;
                cnt_reg <= cnt_reg + 6'd1;
                if (div_last)
                begin
                    frac_reg <= 1'b1;
                    if (frac_reg)
                    begin
                        st_imag_reg <= num_sel[63] ? 33'(64'd0 - qn_reg) : qn_reg[32:0];
                        st_iden_reg <= dq_new[31:0];
                    end
                    else
                    begin
                        st_real_reg <= num_sel[63] ? 33'(64'd0 - qn_reg) : qn_reg[32:0];
                        st_rden_reg <= dq_new[31:0];
                    end
                end
            end
            ST_FINISH:
                if (load_out)
                begin
                    out_real_reg <= st_real_reg;
                    out_imag_reg <= st_imag_reg;
                    out_rden_reg <= st_rden_reg;
                    out_iden_reg <= st_iden_reg;
                    out_mag_reg  <= st_mag_reg;
                    out_dz_reg   <= st_dz_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign div_active    = (state_reg == ST_DIVN) || (state_reg == ST_DIVD);
    assign dz_payload_ok = (out_real_reg == 33'd0) && (out_imag_reg == 33'd0)
                        && (out_rden_reg == 32'd1) && (out_iden_reg == 32'd1);

    `CIA_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
    `CIA_NEVER(a_gcd_v_zero, (state_reg == ST_GCD) && (v_reg == 64'd0))
    `CIA_NEVER(a_div_by_zero, div_active && (g_reg == 64'd0))
    `CIA_ASSERT(a_zero_flag_payload, (m_tvalid && m_tuser) |-> dz_payload_ok)

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// Complex integer ALU core testbench
// Streams directed and random operand pairs through the core under varying
// handshake pressure and checks every result against a local predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cia_pkg::*;

    localparam int W = 16;
    localparam int IN_W = ((3 + 4 * W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [2:0]  opcode;
        logic [15:0] ar, ai, br, bi;
    } operands_t;

    typedef struct {
        logic [32:0] re, im;
        logic [31:0] rden, iden;
        logic [63:0] mag_sq;
        logic        div_zero;
    } alu_result_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
    logic [IN_W-1:0] s_tdata;
    logic [199:0] m_tdata;

    operands_t   pending_ops[$];
    alu_result_t expected_results[$];
    int  src_idle_pct, sink_stall_pct;
    bit  hold_src;
    int  errors;
    int  quiet_cycles;

    complex_integer_alu_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // reduce num/den, sign kept in numerator
    function automatic void reduce_frac(input longint num, input longint unsigned den,
                                        output logic [32:0] n_out,
                                        output logic [31:0] d_out);
        longint unsigned an, g, rn;
        an = (num < 0) ? -num : num;
        g = gcd64(an, den);
        rn = an / g;
        if (num < 0)
            rn = -rn;
        n_out = rn[32:0];
        d_out = 32'(den / g);
    endfunction

    function automatic alu_result_t compute_alu(operands_t op);
        alu_result_t r;
        longint ar, ai, br, bi, re, im;
        longint unsigned den;
        ar = longint'($signed(op.ar));
        ai = longint'($signed(op.ai));
        br = longint'($signed(op.br));
        bi = longint'($signed(op.bi));
        r.rden = 1;
        r.iden = 1;
        r.div_zero = 0;
        if (op.opcode == OP_DIV)
        begin
            den = br * br + bi * bi;
            r.mag_sq = 0;
            if (den == 0)
            begin
                r.re = 0;
                r.im = 0;
                r.div_zero = 1;
            end
            else
            begin
                reduce_frac(ar * br + ai * bi, den, r.re, r.rden);
                reduce_frac(ai * br - ar * bi, den, r.im, r.iden);
            end
            return r;
        end
        case (op.opcode)
            OP_ADD:  begin re = ar + br; im = ai + bi; end
            OP_SUB:  begin re = ar - br; im = ai - bi; end
            OP_MUL:  begin re = ar * br - ai * bi; im = ar * bi + ai * br; end
            default: begin re = ar; im = ai; end
        endcase
        r.re = re[32:0];
        r.im = im[32:0];
        r.mag_sq = re * re + im * im;
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_item(logic [2:0] opc, logic [15:0] ar, logic [15:0] ai,
                            logic [15:0] br, logic [15:0] bi);
        operands_t o;
        o.opcode = opc; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi;
        pending_ops.push_back(o);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0 && !hold_src &&
                    $urandom_range(0, 99) >= src_idle_pct)
                begin
                    operands_t o;
                    o = pending_ops.pop_front();
                    expected_results.push_back(compute_alu(o));
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'({o.bi, o.br, o.ai, o.ar, o.opcode});
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    alu_result_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[32:0] !== e.re)
                    begin
                        $error("res_real exp %h got %h", e.re, m_tdata[32:0]);
                        errors++;
                    end
                    if (m_tdata[65:33] !== e.im)
                    begin
                        $error("res_imag exp %h got %h", e.im, m_tdata[65:33]);
                        errors++;
                    end
                    if (m_tdata[97:66] !== e.rden)
                    begin
                        $error("real_den exp %h got %h", e.rden, m_tdata[97:66]);
                        errors++;
                    end
                    if (m_tdata[129:98] !== e.iden)
                    begin
                        $error("imag_den exp %h got %h", e.iden, m_tdata[129:98]);
                        errors++;
                    end
                    if (m_tdata[193:130] !== e.mag_sq)
                    begin
                        $error("magnitude_sq exp %h got %h", e.mag_sq, m_tdata[193:130]);
                        errors++;
                    end
                    if (m_tuser !== e.div_zero)
                    begin
                        $error("div_zero exp %b got %b", e.div_zero, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_src = 0;
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every opcode, divide corner cases
        for (int op = 0; op < 8; op++)
            add_item(3'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        for (int op = 0; op < 5; op++)
            add_item(3'(op), 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        add_item(OP_DIV, 16'd5, 16'd3, 16'd0, 16'd0);       // zero divisor
        add_item(OP_DIV, 16'd0, 16'd0, 16'd3, 16'd4);       // both numerators zero
        add_item(OP_DIV, 16'd1, 16'd1, 16'd1, 16'hffff);    // real numerator zero
        add_item(OP_DIV, 16'd1, 16'hffff, 16'd1, 16'd1);    // real numerator zero
        add_item(OP_DIV, 16'hfffa, 16'd8, 16'd2, 16'd0);    // negative numerator
        add_item(OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        add_item(OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_item(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_item(OP_SUB, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            for (int i = 0; i < 135; i++)
            begin
                logic [2:0] opc;
                opc = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
                if (opc == OP_DIV && $urandom_range(0, 9) == 0)
                    add_item(opc, rand_operand(), rand_operand(), 16'd0, 16'd0);
                else
                    add_item(opc, rand_operand(), rand_operand(),
                             rand_operand(), rand_operand());
            end
            // sender holds off until the core has fully drained
            if (phase == 1)
            begin
                while (pending_ops.size() > 60)
                    @(posedge clk);
                hold_src = 1;
                while (expected_results.size() != 0)
                    @(posedge clk);
                hold_src = 0;
            end
            wait_drained();
        end

        repeat (600) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/cia_pkg.sv
rtl/complex_integer_alu_core.sv
test/testbench.sv
